>>> design/bpfa_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and helper functions of the page frame allocator
package bpfa_pkg;

	localparam int unsigned MAX_PAGES_DEF     = 65536;
	localparam int unsigned MAP_WORD_BITS_DEF = 64;

	localparam int unsigned CNT_W       = 17;
	localparam int unsigned PAGE_W      = 16;
	localparam int unsigned OP_W        = 3;
	localparam int unsigned USE_W       = 32;
	localparam int unsigned APB_DW      = 32;
	localparam int unsigned APB_AW      = 3;
	localparam int unsigned REG_IDX_W   = APB_AW - 2;
	localparam int unsigned TOTAL_RESET = 65536;
	localparam int unsigned CNT_MAX     = (1 << CNT_W) - 1;

	localparam logic [REG_IDX_W-1:0] REG_PAGE_TOTAL = '0;

	localparam logic [OP_W-1:0] OP_REQUEST   = 3'd0;
	localparam logic [OP_W-1:0] OP_FREE      = 3'd1;
	localparam logic [OP_W-1:0] OP_LOCK      = 3'd2;
	localparam logic [OP_W-1:0] OP_RESERVE   = 3'd3;
	localparam logic [OP_W-1:0] OP_UNRESERVE = 3'd4;

	localparam logic STS_DONE      = 1'b0;
	localparam logic STS_EXHAUSTED = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [PAGE_W-1:0] first_page;
		logic [CNT_W-1:0]  run_length;
	} in_item_t;

	typedef struct packed {
		logic              status;
		logic [PAGE_W-1:0] granted_page;
		logic [CNT_W-1:0]  free_pages;
		logic [CNT_W-1:0]  used_pages;
		logic [CNT_W-1:0]  reserved_pages;
	} out_item_t;

	// page total write seen on the register port
	typedef struct packed {
		logic             wr;
		logic [CNT_W-1:0] total;
	} cfg_evt_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN_RD,
		ST_RUN_LOAD,
		ST_RUN_BIT,
		ST_RUN_WB,
		ST_REQ_RD,
		ST_REQ_SCAN,
		ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_ACCEPT,
		CMD_RD_RUN,
		CMD_LOAD,
		CMD_BIT,
		CMD_WB,
		CMD_RD_REQ,
		CMD_SCAN,
		CMD_EXHAUST,
		CMD_RESULT
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic run_done;
		logic bit_last;
		logic req_none;
		logic scan_hit;
	} dp_stat_t;

	function automatic logic [CNT_W-1:0] reset_total(input int unsigned max_pages);
		return (max_pages < TOTAL_RESET) ? CNT_W'(max_pages) : CNT_W'(TOTAL_RESET);
	endfunction

	function automatic logic [CNT_W-1:0] clamp_total(input int unsigned max_pages);
		return (max_pages < CNT_MAX) ? CNT_W'(max_pages) : CNT_W'(CNT_MAX);
	endfunction

endpackage

>>> design/bpfa_chan_if.sv
`timescale 1ns / 1ps
// valid/ready channel carrying one item per handshake
interface bpfa_chan_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

>>> design/bitmap_page_frame_allocator.sv
`timescale 1ns / 1ps
// top level of the bitmap page frame allocator
//
//   channel  dir  handshake                    carries
//   req      in   valid/ready                  operation, first_page, run_length
//   rsp      out  valid/ready                  status, granted_page, page counts
//   apb      in   psel/penable, pready high    page_total at byte address 0
//
// request: accept, then a row read and a scan per bitmap row tried, then finish; an exhausted
// bitmap adds an exhaust step. free/lock/reserve/unreserve: per row touched a read, a load
// into the word buffer, one bit step per page and a write back, then finish
// reset and every page_total write start a clearing pass of one row per cycle,
// during which no item is accepted
// a finished result waits in the output register; the next item is taken meanwhile
module bitmap_page_frame_allocator #(
	parameter int unsigned MAX_PAGES     = bpfa_pkg::MAX_PAGES_DEF,
	parameter int unsigned MAP_WORD_BITS = bpfa_pkg::MAP_WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bpfa_pkg::APB_AW-1:0]   paddr,
	input  logic [bpfa_pkg::APB_DW-1:0]   pwdata,
	output logic [bpfa_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	bpfa_chan_if.sink                     req,
	bpfa_chan_if.source                   rsp
);
	bpfa_pkg::cfg_evt_t         cfg;
	logic [bpfa_pkg::CNT_W-1:0] page_total;
	bpfa_pkg::dp_stat_t         stat;
	bpfa_pkg::dp_cmd_t          cmd;
	bpfa_pkg::in_item_t         item;
	bpfa_pkg::out_item_t        result;
	logic                       req_ready;
	logic                       rsp_valid;

	assign item = req.payload;

	bpfa_apb #(
		.MAX_PAGES(MAX_PAGES)
	) u_apb (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cfg       (cfg),
		.page_total(page_total)
	);

	bpfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg.wr),
		.req_valid(req.valid),
		.req_op   (item.operation),
		.req_ready(req_ready),
		.rsp_ready(rsp.ready),
		.rsp_valid(rsp_valid),
		.stat     (stat),
		.cmd      (cmd)
	);

	bpfa_dp #(
		.MAX_PAGES    (MAX_PAGES),
		.MAP_WORD_BITS(MAP_WORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg),
		.page_total(page_total),
		.item      (item),
		.stat      (stat),
		.result    (result)
	);

	assign req.ready   = req_ready;
	assign rsp.valid   = rsp_valid;
	assign rsp.payload = result;
endmodule

>>> design/bpfa_apb.sv
`timescale 1ns / 1ps
// register port holding the page total
module bpfa_apb #(
	parameter int unsigned MAX_PAGES = bpfa_pkg::MAX_PAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bpfa_pkg::APB_AW-1:0]   paddr,
	input  logic [bpfa_pkg::APB_DW-1:0]   pwdata,
	output logic [bpfa_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output bpfa_pkg::cfg_evt_t            cfg,
	output logic [bpfa_pkg::CNT_W-1:0]    page_total
);
	localparam logic [bpfa_pkg::CNT_W-1:0] CLAMP     = bpfa_pkg::clamp_total(MAX_PAGES);
	localparam logic [bpfa_pkg::CNT_W-1:0] TOTAL_RST = bpfa_pkg::reset_total(MAX_PAGES);

	logic [bpfa_pkg::CNT_W-1:0] page_total_q;
	logic [bpfa_pkg::CNT_W-1:0] wr_raw;
	logic                       hit;

	assign hit    = paddr[bpfa_pkg::APB_AW-1:2] == bpfa_pkg::REG_PAGE_TOTAL;
	assign wr_raw = pwdata[bpfa_pkg::CNT_W-1:0];

	assign cfg.wr    = psel & penable & pwrite & hit;
	assign cfg.total = (wr_raw > CLAMP) ? CLAMP : wr_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_total_q <= TOTAL_RST;
		end else if (cfg.wr) begin
			page_total_q <= cfg.total;
		end
	end

	assign page_total = page_total_q;
	assign prdata     = hit ? bpfa_pkg::APB_DW'(page_total_q) : '0;
	assign pready     = 1'b1;
endmodule

>>> design/bpfa_ctrl.sv
`timescale 1ns / 1ps
// sequencer of the allocator: steps the datapath through clear, scan and run walks
module bpfa_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr,
	input  logic                       req_valid,
	input  logic [bpfa_pkg::OP_W-1:0]  req_op,
	output logic                       req_ready,
	input  logic                       rsp_ready,
	output logic                       rsp_valid,
	input  bpfa_pkg::dp_stat_t         stat,
	output bpfa_pkg::dp_cmd_t          cmd
);
	bpfa_pkg::state_t state_q, state_d;
	logic             rsp_valid_q;
	logic             out_ok;
	logic             run_op;

	assign out_ok = !rsp_valid_q || rsp_ready;
	assign run_op = (req_op == bpfa_pkg::OP_FREE) || (req_op == bpfa_pkg::OP_LOCK) ||
		(req_op == bpfa_pkg::OP_RESERVE) || (req_op == bpfa_pkg::OP_UNRESERVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpfa_pkg::ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd == bpfa_pkg::CMD_RESULT) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		if (cfg_wr) begin
			state_d = bpfa_pkg::ST_CLEAR;
		end else begin
			unique case (state_q)
				bpfa_pkg::ST_CLEAR: begin
					if (stat.clr_last) state_d = bpfa_pkg::ST_IDLE;
				end
				bpfa_pkg::ST_IDLE: begin
					if (req_valid) begin
						if (req_op == bpfa_pkg::OP_REQUEST) state_d = bpfa_pkg::ST_REQ_RD;
						else if (run_op) state_d = bpfa_pkg::ST_RUN_RD;
						else state_d = bpfa_pkg::ST_FINISH;
					end
				end
				bpfa_pkg::ST_RUN_RD: begin
					state_d = stat.run_done ? bpfa_pkg::ST_FINISH : bpfa_pkg::ST_RUN_LOAD;
				end
				bpfa_pkg::ST_RUN_LOAD: state_d = bpfa_pkg::ST_RUN_BIT;
				bpfa_pkg::ST_RUN_BIT: begin
					if (stat.bit_last) state_d = bpfa_pkg::ST_RUN_WB;
				end
				bpfa_pkg::ST_RUN_WB: state_d = bpfa_pkg::ST_RUN_RD;
				bpfa_pkg::ST_REQ_RD: begin
					state_d = stat.req_none ? bpfa_pkg::ST_FINISH : bpfa_pkg::ST_REQ_SCAN;
				end
				bpfa_pkg::ST_REQ_SCAN: begin
					state_d = stat.scan_hit ? bpfa_pkg::ST_FINISH : bpfa_pkg::ST_REQ_RD;
				end
				bpfa_pkg::ST_FINISH: begin
					if (out_ok) state_d = bpfa_pkg::ST_IDLE;
				end
				default: state_d = bpfa_pkg::ST_CLEAR;
			endcase
		end
	end

	// datapath command and handshake
	always_comb begin
		cmd       = bpfa_pkg::CMD_NONE;
		req_ready = 1'b0;
		if (!cfg_wr) begin
			unique case (state_q)
				bpfa_pkg::ST_CLEAR: cmd = bpfa_pkg::CMD_CLEAR;
				bpfa_pkg::ST_IDLE: begin
					req_ready = 1'b1;
					if (req_valid) cmd = bpfa_pkg::CMD_ACCEPT;
				end
				bpfa_pkg::ST_RUN_RD: begin
					if (!stat.run_done) cmd = bpfa_pkg::CMD_RD_RUN;
				end
				bpfa_pkg::ST_RUN_LOAD: cmd = bpfa_pkg::CMD_LOAD;
				bpfa_pkg::ST_RUN_BIT:  cmd = bpfa_pkg::CMD_BIT;
				bpfa_pkg::ST_RUN_WB:   cmd = bpfa_pkg::CMD_WB;
				bpfa_pkg::ST_REQ_RD: begin
					cmd = stat.req_none ? bpfa_pkg::CMD_EXHAUST : bpfa_pkg::CMD_RD_REQ;
				end
				bpfa_pkg::ST_REQ_SCAN: cmd = bpfa_pkg::CMD_SCAN;
				bpfa_pkg::ST_FINISH: begin
					if (out_ok) cmd = bpfa_pkg::CMD_RESULT;
				end
				default: cmd = bpfa_pkg::CMD_NONE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
endmodule

>>> design/bpfa_dp.sv
`timescale 1ns / 1ps
// datapath: busy bitmap memory, word buffer, search hint, page counters, result register
module bpfa_dp #(
	parameter int unsigned MAX_PAGES     = bpfa_pkg::MAX_PAGES_DEF,
	parameter int unsigned MAP_WORD_BITS = bpfa_pkg::MAP_WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bpfa_pkg::dp_cmd_t           cmd,
	input  bpfa_pkg::cfg_evt_t          cfg,
	input  logic [bpfa_pkg::CNT_W-1:0]  page_total,
	input  bpfa_pkg::in_item_t          item,
	output bpfa_pkg::dp_stat_t          stat,
	output bpfa_pkg::out_item_t         result
);
	localparam int unsigned CW    = bpfa_pkg::CNT_W;
	localparam int unsigned UW    = bpfa_pkg::USE_W;
	localparam int unsigned BIT_W = $clog2(MAP_WORD_BITS);
	// rows are a power of two wide, so page to row is a shift
	localparam int unsigned RW    = 1 << BIT_W;
	localparam int unsigned ROWS  = (MAX_PAGES + RW - 1) / RW;
	localparam int unsigned AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned XW    = (AW + BIT_W > CW) ? AW + BIT_W : CW;
	localparam logic [CW-1:0] TOTAL_RST = bpfa_pkg::reset_total(MAX_PAGES);
	localparam logic [AW-1:0] LAST_ROW  = AW'(ROWS - 1);

	logic [RW-1:0] mem [ROWS];
	logic [RW-1:0] rd_data_q;
	logic [RW-1:0] word_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] clr_q;

	logic [bpfa_pkg::OP_W-1:0]   op_q;
	logic [CW-1:0]               cur_q;
	logic [CW-1:0]               remain_q;
	logic [CW-1:0]               hint_q;
	logic [CW-1:0]               free_q;
	logic [bpfa_pkg::USE_W-1:0]  used_q;
	logic [bpfa_pkg::USE_W-1:0]  resv_q;
	logic                        exh_q;
	logic [bpfa_pkg::PAGE_W-1:0] grant_q;
	bpfa_pkg::out_item_t         result_q;

	logic [XW-1:0]    cur_x, hint_x;
	logic [AW-1:0]    row_cur, row_hint, rd_addr;
	logic [BIT_W-1:0] cur_off, hint_off, tot_off, hit_idx;
	logic             same_row;
	logic [RW-1:0]    scan_ok, scan_free;
	logic [CW-1:0]    grant_page, next_hint;
	logic [CW:0]      next_row, cur_inc;
	logic             set_v, change;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [RW-1:0]    mem_wdata;

	assign cur_x    = XW'(cur_q);
	assign hint_x   = XW'(hint_q);
	assign row_cur  = cur_x[BIT_W +: AW];
	assign row_hint = hint_x[BIT_W +: AW];
	assign cur_off  = cur_q[BIT_W-1:0];
	assign hint_off = hint_q[BIT_W-1:0];
	assign tot_off  = page_total[BIT_W-1:0];
	assign same_row = hint_q[CW-1:BIT_W] == page_total[CW-1:BIT_W];

	// pages of the row at or above the hint and below the page total
	always_comb begin
		for (int j = 0; j < RW; j++) begin
			scan_ok[j] = (BIT_W'(j) >= hint_off) && (!same_row || (BIT_W'(j) < tot_off));
		end
	end

	assign scan_free = ~rd_data_q & scan_ok;

	// lowest free page of the row
	always_comb begin
		hit_idx = '0;
		for (int j = RW - 1; j >= 0; j--) begin
			if (scan_free[j]) hit_idx = BIT_W'(j);
		end
	end

	assign grant_page = {hint_q[CW-1:BIT_W], hit_idx};
	assign next_row   = ({1'b0, hint_q} | (CW + 1)'(RW - 1)) + (CW + 1)'(1);
	assign next_hint  = (next_row >= {1'b0, page_total}) ? page_total : next_row[CW-1:0];

	assign set_v   = (op_q == bpfa_pkg::OP_LOCK) || (op_q == bpfa_pkg::OP_RESERVE);
	assign change  = word_q[cur_off] != set_v;
	assign cur_inc = {1'b0, cur_q} + (CW + 1)'(1);

	assign stat.clr_last = clr_q == LAST_ROW;
	assign stat.run_done = (remain_q == '0) || (cur_q >= page_total);
	assign stat.bit_last = (remain_q == CW'(1)) || (&cur_off) || (cur_inc == {1'b0, page_total});
	assign stat.req_none = hint_q >= page_total;
	assign stat.scan_hit = |scan_free;

	// bitmap memory: one write and one registered read per cycle
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = word_q;
		unique case (cmd)
			bpfa_pkg::CMD_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			bpfa_pkg::CMD_WB: mem_we = 1'b1;
			bpfa_pkg::CMD_SCAN: begin
				mem_we    = stat.scan_hit;
				mem_wdata = rd_data_q | (RW'(1) << hit_idx);
			end
			default: mem_we = 1'b0;
		endcase
	end

	assign rd_addr = (cmd == bpfa_pkg::CMD_RD_REQ) ? row_hint : row_cur;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_data_q <= mem[rd_addr];
	end

	// hint, counters and clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_q <= '0;
			free_q <= TOTAL_RST;
			used_q <= '0;
			resv_q <= '0;
			clr_q  <= '0;
		end else if (cfg.wr) begin
			hint_q <= '0;
			free_q <= cfg.total;
			used_q <= '0;
			resv_q <= '0;
			clr_q  <= '0;
		end else begin
			unique case (cmd)
				bpfa_pkg::CMD_CLEAR: clr_q <= clr_q + AW'(1);
				bpfa_pkg::CMD_BIT: begin
					if (change) begin
						if (set_v) begin
							free_q <= (free_q == '0) ? '0 : free_q - CW'(1);
							if (op_q == bpfa_pkg::OP_LOCK) used_q <= used_q + UW'(1);
							else resv_q <= resv_q + UW'(1);
						end else begin
							if (cur_q < hint_q) hint_q <= cur_q;
							free_q <= free_q + CW'(1);
							if (op_q == bpfa_pkg::OP_FREE) begin
								used_q <= (used_q == '0) ? '0 : used_q - UW'(1);
							end else begin
								resv_q <= (resv_q == '0) ? '0 : resv_q - UW'(1);
							end
						end
					end
				end
				bpfa_pkg::CMD_SCAN: begin
					if (stat.scan_hit) begin
						hint_q <= grant_page;
						free_q <= (free_q == '0) ? '0 : free_q - CW'(1);
						used_q <= used_q + UW'(1);
					end else begin
						hint_q <= next_hint;
					end
				end
				default: ;
			endcase
		end
	end

	// item fields, word buffer and result
	always_ff @(posedge clk) begin
		unique case (cmd)
			bpfa_pkg::CMD_ACCEPT: begin
				op_q     <= item.operation;
				cur_q    <= CW'(item.first_page);
				remain_q <= item.run_length;
				exh_q    <= 1'b0;
				grant_q  <= '0;
			end
			bpfa_pkg::CMD_RD_RUN: addr_q <= row_cur;
			bpfa_pkg::CMD_RD_REQ: addr_q <= row_hint;
			bpfa_pkg::CMD_LOAD:   word_q <= rd_data_q;
			bpfa_pkg::CMD_BIT: begin
				word_q[cur_off] <= set_v;
				cur_q           <= cur_inc[CW-1:0];
				remain_q        <= remain_q - CW'(1);
			end
			bpfa_pkg::CMD_SCAN: begin
				if (stat.scan_hit) grant_q <= grant_page[bpfa_pkg::PAGE_W-1:0];
			end
			bpfa_pkg::CMD_EXHAUST: exh_q <= 1'b1;
			bpfa_pkg::CMD_RESULT: begin
				result_q.status         <= exh_q ? bpfa_pkg::STS_EXHAUSTED : bpfa_pkg::STS_DONE;
				result_q.granted_page   <= grant_q;
				result_q.free_pages     <= free_q;
				result_q.used_pages     <= used_q[CW-1:0];
				result_q.reserved_pages <= resv_q[CW-1:0];
			end
			default: ;
		endcase
	end

	assign result = result_q;
endmodule
